FILE: rtl/core/dcb_pkg.sv
package dcb_pkg;

    localparam int unsigned TMR_W   = 16;
    localparam int unsigned NUM_TMR = 3;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned CODE_W  = 3;

    // timer slots
    localparam logic [1:0] TMR_REP  = 2'd0;
    localparam logic [1:0] TMR_IDLE = 2'd1;
    localparam logic [1:0] TMR_AUTO = 2'd2;

    // pending press bits
    localparam logic [1:0] PEND_RESET = 2'd0;
    localparam logic [1:0] PEND_INC   = 2'd1;
    localparam logic [1:0] PEND_DEC   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_IDLE_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd1;
    localparam logic [1:0] CFG_AUTO_PERIOD   = 2'd2;

    localparam logic [TMR_W-1:0] IDLE_TIMEOUT_RST  = 16'd1000;
    localparam logic [TMR_W-1:0] REPEAT_PERIOD_RST = 16'd100;
    localparam logic [TMR_W-1:0] AUTO_PERIOD_RST   = 16'd100;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    // reported mode codes
    localparam logic [CODE_W-1:0] CODE_INIT     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_IDLE     = 3'd1;
    localparam logic [CODE_W-1:0] CODE_RESET    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_INC      = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DEC      = 3'd4;
    localparam logic [CODE_W-1:0] CODE_INC_HOLD = 3'd5;
    localparam logic [CODE_W-1:0] CODE_DEC_HOLD = 3'd6;

    typedef enum logic [7:0] {
        MODE_INIT     = 8'b0000_0001,
        MODE_IDLE     = 8'b0000_0010,
        MODE_RESET    = 8'b0000_0100,
        MODE_INC      = 8'b0000_1000,
        MODE_DEC      = 8'b0001_0000,
        MODE_INC_HOLD = 8'b0010_0000,
        MODE_DEC_HOLD = 8'b0100_0000,
        MODE_AUTO     = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [TMR_W-1:0] idle_timeout;
        logic [TMR_W-1:0] repeat_period;
        logic [TMR_W-1:0] auto_period;
    } cfg_t;

    typedef struct packed {
        logic [NUM_TMR-1:0]            load;
        logic [NUM_TMR-1:0][TMR_W-1:0] value;
    } tmr_cmd_t;

    function automatic logic [DIGIT_W-1:0] digit_up(input logic [DIGIT_W-1:0] d);
        digit_up = (d >= DIGIT_MAX) ? '0 : d + 4'd1;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_down(input logic [DIGIT_W-1:0] d);
        digit_down = (d == '0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
    endfunction

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_INIT:     c = CODE_INIT;
            MODE_IDLE:     c = CODE_IDLE;
            MODE_RESET:    c = CODE_RESET;
            MODE_INC:      c = CODE_INC;
            MODE_DEC:      c = CODE_DEC;
            MODE_INC_HOLD: c = CODE_INC_HOLD;
            MODE_DEC_HOLD: c = CODE_DEC_HOLD;
            default:       c = CODE_IDLE;
        endcase
        mode_code = c;
    endfunction

endpackage

FILE: rtl/core/digit_counter_button_fsm_core.sv
// A result appears on m_tvalid in the cycle after its request is taken.
// Throughput: one request per cycle unless m_tready stalls; the state update
// and the result are one combinational step into the result register, which
// refills as it drains. Reset: async active low; digit 0, mode init, no pending
// presses, timers stopped, registers back to 1000 / 100 / 100, no result held.
module digit_counter_button_fsm_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // tick, rst_evt, inc_evt, dec_evt, inc_held,
                                   // dec_held, 2'b0
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // digit[3:0], mode[6:4], auto_active[7]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    dcb_pkg::cfg_t                   cfg_reg;
    dcb_pkg::tmr_cmd_t               cmd;
    logic [dcb_pkg::NUM_TMR-1:0]     expired;
    logic [dcb_pkg::DIGIT_W-1:0]     digit;
    logic [dcb_pkg::CODE_W-1:0]      mode;
    logic                            auto_active;
    logic                            accept;
    logic                            out_valid_reg;
    logic [7:0]                      out_data_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_timeout  <= dcb_pkg::IDLE_TIMEOUT_RST;
            cfg_reg.repeat_period <= dcb_pkg::REPEAT_PERIOD_RST;
            cfg_reg.auto_period   <= dcb_pkg::AUTO_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dcb_pkg::CFG_IDLE_TIMEOUT:  cfg_reg.idle_timeout  <= cfg_wdata;
                dcb_pkg::CFG_REPEAT_PERIOD: cfg_reg.repeat_period <= cfg_wdata;
                dcb_pkg::CFG_AUTO_PERIOD:   cfg_reg.auto_period   <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    dcb_timers u_timers
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .tick    (s_tdata[0]),
        .cmd     (cmd),
        .expired (expired)
    );

    dcb_fsm u_fsm
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cfg         (cfg_reg),
        .rst_evt     (s_tdata[1]),
        .inc_evt     (s_tdata[2]),
        .dec_evt     (s_tdata[3]),
        .inc_held    (s_tdata[4]),
        .dec_held    (s_tdata[5]),
        .expired     (expired),
        .cmd         (cmd),
        .digit       (digit),
        .mode        (mode),
        .auto_active (auto_active)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {auto_active, mode, digit};
        end
    end

endmodule

FILE: rtl/core/dcb_timers.sv
module dcb_timers
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     tick,
    input  dcb_pkg::tmr_cmd_t        cmd,
    output logic [dcb_pkg::NUM_TMR-1:0] expired
);

    logic [dcb_pkg::NUM_TMR-1:0][dcb_pkg::TMR_W-1:0] count_reg;
    logic [dcb_pkg::NUM_TMR-1:0][dcb_pkg::TMR_W-1:0] count_tick;
    logic [dcb_pkg::NUM_TMR-1:0][dcb_pkg::TMR_W-1:0] count_next;
    logic [dcb_pkg::NUM_TMR-1:0]                     exp_reg;
    logic [dcb_pkg::NUM_TMR-1:0]                     exp_next;

    // tick applies first, loads from the state machine override
    always_comb
    begin
        for (int t = 0; t < dcb_pkg::NUM_TMR; t++)
        begin
            count_tick[t] = count_reg[t];
            expired[t]    = exp_reg[t];
            if (tick && count_reg[t] != '0)
            begin
                count_tick[t] = count_reg[t] - 16'd1;
                if (count_reg[t] == 16'd1)
                begin
                    expired[t] = 1'b1;
                end
            end
            count_next[t] = cmd.load[t] ? cmd.value[t] : count_tick[t];
            exp_next[t]   = cmd.load[t] ? 1'b0 : expired[t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            exp_reg   <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

endmodule

FILE: rtl/core/dcb_fsm.sv
module dcb_fsm
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  dcb_pkg::cfg_t                  cfg,
    input  logic                           rst_evt,
    input  logic                           inc_evt,
    input  logic                           dec_evt,
    input  logic                           inc_held,
    input  logic                           dec_held,
    input  logic [dcb_pkg::NUM_TMR-1:0]    expired,
    output dcb_pkg::tmr_cmd_t              cmd,
    output logic [dcb_pkg::DIGIT_W-1:0]    digit,
    output logic [dcb_pkg::CODE_W-1:0]     mode,
    output logic                           auto_active
);

    dcb_pkg::mode_t             mode_reg, mode_next;
    logic [dcb_pkg::DIGIT_W-1:0] digit_reg, digit_next;
    logic [2:0]                 pend_reg, pend_next;
    logic [2:0]                 pend_l;

    always_comb
    begin
        pend_l     = pend_reg | {dec_evt, inc_evt, rst_evt};
        pend_next  = pend_l;
        mode_next  = mode_reg;
        digit_next = digit_reg;
        cmd        = '0;
        unique case (mode_reg)
            dcb_pkg::MODE_INIT:
            begin
                mode_next = dcb_pkg::MODE_IDLE;
            end
            dcb_pkg::MODE_IDLE:
            begin
                if (expired[dcb_pkg::TMR_IDLE])
                begin
                    cmd.load[dcb_pkg::TMR_AUTO]  = 1'b1;
                    cmd.value[dcb_pkg::TMR_AUTO] = cfg.auto_period;
                    cmd.load[dcb_pkg::TMR_IDLE]  = 1'b1;
                    mode_next = dcb_pkg::MODE_AUTO;
                end
                else if (pend_l[dcb_pkg::PEND_RESET])
                begin
                    pend_next[dcb_pkg::PEND_RESET] = 1'b0;
                    mode_next = dcb_pkg::MODE_RESET;
                end
                else if (pend_l[dcb_pkg::PEND_INC])
                begin
                    pend_next[dcb_pkg::PEND_INC] = 1'b0;
                    mode_next = dcb_pkg::MODE_INC;
                end
                else if (inc_held)
                begin
                    cmd.load[dcb_pkg::TMR_REP]  = 1'b1;
                    cmd.value[dcb_pkg::TMR_REP] = cfg.repeat_period;
                    digit_next = dcb_pkg::digit_up(digit_reg);
                    mode_next  = dcb_pkg::MODE_INC_HOLD;
                end
                else if (dec_held)
                begin
                    cmd.load[dcb_pkg::TMR_REP]  = 1'b1;
                    cmd.value[dcb_pkg::TMR_REP] = cfg.repeat_period;
                    digit_next = dcb_pkg::digit_down(digit_reg);
                    mode_next  = dcb_pkg::MODE_DEC_HOLD;
                end
                else if (pend_l[dcb_pkg::PEND_DEC])
                begin
                    pend_next[dcb_pkg::PEND_DEC] = 1'b0;
                    mode_next = dcb_pkg::MODE_DEC;
                end
            end
            dcb_pkg::MODE_RESET, dcb_pkg::MODE_INC, dcb_pkg::MODE_DEC:
            begin
                if (mode_reg == dcb_pkg::MODE_RESET)
                begin
                    digit_next = '0;
                end
                else if (mode_reg == dcb_pkg::MODE_INC)
                begin
                    digit_next = dcb_pkg::digit_up(digit_reg);
                end
                else
                begin
                    digit_next = dcb_pkg::digit_down(digit_reg);
                end
                cmd.load[dcb_pkg::TMR_IDLE]  = 1'b1;
                cmd.value[dcb_pkg::TMR_IDLE] = cfg.idle_timeout;
                mode_next = dcb_pkg::MODE_IDLE;
            end
            dcb_pkg::MODE_INC_HOLD, dcb_pkg::MODE_DEC_HOLD:
            begin
                // release stops the repeat timer, which also drops its flag
                if ((mode_reg == dcb_pkg::MODE_INC_HOLD) ? !inc_held : !dec_held)
                begin
                    cmd.load[dcb_pkg::TMR_IDLE]  = 1'b1;
                    cmd.value[dcb_pkg::TMR_IDLE] = cfg.idle_timeout;
                    cmd.load[dcb_pkg::TMR_REP]   = 1'b1;
                    mode_next = dcb_pkg::MODE_IDLE;
                end
                else if (expired[dcb_pkg::TMR_REP])
                begin
                    cmd.load[dcb_pkg::TMR_REP]  = 1'b1;
                    cmd.value[dcb_pkg::TMR_REP] = cfg.repeat_period;
                    digit_next = (mode_reg == dcb_pkg::MODE_INC_HOLD)
                               ? dcb_pkg::digit_up(digit_reg)
                               : dcb_pkg::digit_down(digit_reg);
                end
            end
            default:
            begin
                if (expired[dcb_pkg::TMR_AUTO])
                begin
                    cmd.load[dcb_pkg::TMR_AUTO] = 1'b1;
                    if (digit_reg <= 4'd1)
                    begin
                        digit_next = '0;
                        mode_next  = dcb_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        cmd.value[dcb_pkg::TMR_AUTO] = cfg.auto_period;
                        digit_next = digit_reg - 4'd1;
                    end
                end
                if (pend_l[dcb_pkg::PEND_INC])
                begin
                    pend_next[dcb_pkg::PEND_INC] = 1'b0;
                    mode_next = dcb_pkg::MODE_INC;
                end
                else if (pend_l[dcb_pkg::PEND_DEC])
                begin
                    pend_next[dcb_pkg::PEND_DEC] = 1'b0;
                    mode_next = dcb_pkg::MODE_DEC;
                end
            end
        endcase
    end

    assign digit       = digit_next;
    assign mode        = dcb_pkg::mode_code(mode_next);
    assign auto_active = (mode_next == dcb_pkg::MODE_AUTO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dcb_pkg::MODE_INIT;
            digit_reg <= '0;
            pend_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            digit_reg <= digit_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dcb_pkg::*;

    typedef struct packed {
        logic [1:0] pad;
        logic       dec_held;
        logic       inc_held;
        logic       dec_evt;
        logic       inc_evt;
        logic       rst_evt;
        logic       tick;
    } request_t;

    typedef struct packed {
        logic              auto_active;
        logic [CODE_W-1:0] mode;
        logic [DIGIT_W-1:0] digit;
    } display_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    digit_counter_button_fsm_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    mode_t              fsm;
    logic [DIGIT_W-1:0] digit_q;
    logic [2:0]         pend;
    logic [TMR_W-1:0]   tmr_cnt [NUM_TMR];
    logic               tmr_flag [NUM_TMR];
    logic [TMR_W-1:0]   cfg_idle;
    logic [TMR_W-1:0]   cfg_repeat;
    logic [TMR_W-1:0]   cfg_auto;

    display_t expected_display [$];

    int errors;
    int items_sent;
    int results_checked;
    int reg_writes;
    int auto_entries;
    int hold_entries;

    // stimulus shaping
    logic no_idle;
    logic hold_req;
    int   hold_len;
    logic inc_level;
    logic dec_level;
    int   calm_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void load_timer(input logic [1:0] t, input logic [TMR_W-1:0] n);
        tmr_cnt[t]  = n;
        tmr_flag[t] = 1'b0;
    endfunction

    function automatic logic claim(input logic [1:0] p);
        claim   = pend[p];
        pend[p] = 1'b0;
    endfunction

    function automatic logic [DIGIT_W-1:0] next_up(input logic [DIGIT_W-1:0] d);
        if (d >= DIGIT_MAX)
            return '0;
        return d + 1'b1;
    endfunction

    function automatic logic [DIGIT_W-1:0] next_down(input logic [DIGIT_W-1:0] d);
        if (d == '0 || d > DIGIT_MAX)
            return DIGIT_MAX;
        return d - 1'b1;
    endfunction

    function automatic void leave_hold();
        load_timer(TMR_IDLE, cfg_idle);
        fsm = MODE_IDLE;
        load_timer(TMR_REP, '0);
    endfunction

    function automatic void reset_predictor();
        int t;
        fsm        = MODE_INIT;
        digit_q    = '0;
        pend       = '0;
        cfg_idle   = IDLE_TIMEOUT_RST;
        cfg_repeat = REPEAT_PERIOD_RST;
        cfg_auto   = AUTO_PERIOD_RST;
        for (t = 0; t < NUM_TMR; t++)
        begin
            tmr_cnt[t]  = '0;
            tmr_flag[t] = 1'b0;
        end
    endfunction

    function automatic display_t predict_display(input request_t r);
        display_t res;
        int t;
        if (r.rst_evt) pend[PEND_RESET] = 1'b1;
        if (r.inc_evt) pend[PEND_INC]   = 1'b1;
        if (r.dec_evt) pend[PEND_DEC]   = 1'b1;
        if (r.tick)
            for (t = 0; t < NUM_TMR; t++)
                if (tmr_cnt[t] != '0)
                begin
                    tmr_cnt[t] = tmr_cnt[t] - 1'b1;
                    if (tmr_cnt[t] == '0)
                        tmr_flag[t] = 1'b1;
                end

        case (fsm)
            MODE_INIT:
                fsm = MODE_IDLE;
            MODE_IDLE:
                if (tmr_flag[TMR_IDLE])
                begin
                    load_timer(TMR_AUTO, cfg_auto);
                    load_timer(TMR_IDLE, '0);
                    fsm = MODE_AUTO;
                    auto_entries++;
                end
                else if (claim(PEND_RESET))
                    fsm = MODE_RESET;
                else if (claim(PEND_INC))
                    fsm = MODE_INC;
                else if (r.inc_held)
                begin
                    load_timer(TMR_REP, cfg_repeat);
                    digit_q = next_up(digit_q);
                    fsm = MODE_INC_HOLD;
                    hold_entries++;
                end
                else if (r.dec_held)
                begin
                    load_timer(TMR_REP, cfg_repeat);
                    digit_q = next_down(digit_q);
                    fsm = MODE_DEC_HOLD;
                    hold_entries++;
                end
                else if (claim(PEND_DEC))
                    fsm = MODE_DEC;
            MODE_RESET:
            begin
                digit_q = '0;
                load_timer(TMR_IDLE, cfg_idle);
                fsm = MODE_IDLE;
            end
            MODE_INC:
            begin
                digit_q = next_up(digit_q);
                load_timer(TMR_IDLE, cfg_idle);
                fsm = MODE_IDLE;
            end
            MODE_DEC:
            begin
                digit_q = next_down(digit_q);
                load_timer(TMR_IDLE, cfg_idle);
                fsm = MODE_IDLE;
            end
            MODE_INC_HOLD:
            begin
                if (!r.inc_held)
                    leave_hold();
                if (tmr_flag[TMR_REP])
                begin
                    load_timer(TMR_REP, cfg_repeat);
                    digit_q = next_up(digit_q);
                end
            end
            MODE_DEC_HOLD:
            begin
                if (!r.dec_held)
                    leave_hold();
                if (tmr_flag[TMR_REP])
                begin
                    load_timer(TMR_REP, cfg_repeat);
                    digit_q = next_down(digit_q);
                end
            end
            default:
            begin
                if (tmr_flag[TMR_AUTO])
                begin
                    load_timer(TMR_AUTO, cfg_auto);
                    if (digit_q <= 4'd1)
                    begin
                        digit_q = '0;
                        load_timer(TMR_AUTO, '0);
                        fsm = MODE_IDLE;
                    end
                    else
                        digit_q = digit_q - 1'b1;
                end
                if (claim(PEND_INC))
                    fsm = MODE_INC;
                else if (claim(PEND_DEC))
                    fsm = MODE_DEC;
            end
        endcase

        res.digit       = digit_q;
        res.auto_active = (fsm == MODE_AUTO);
        case (fsm)
            MODE_INIT:     res.mode = CODE_INIT;
            MODE_RESET:    res.mode = CODE_RESET;
            MODE_INC:      res.mode = CODE_INC;
            MODE_DEC:      res.mode = CODE_DEC;
            MODE_INC_HOLD: res.mode = CODE_INC_HOLD;
            MODE_DEC_HOLD: res.mode = CODE_DEC_HOLD;
            default:       res.mode = CODE_IDLE;
        endcase
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        display_t want;
        display_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_display.size() == 0)
            begin
                $error("unexpected result: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_display.pop_front();
                results_checked++;
                if (got.digit !== want.digit)
                begin
                    $error("digit: expected %0d, got %0d", want.digit, got.digit);
                    errors++;
                end
                if (got.mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, got.mode);
                    errors++;
                end
                if (got.auto_active !== want.auto_active)
                begin
                    $error("auto_active: expected %0d, got %0d",
                           want.auto_active, got.auto_active);
                    errors++;
                end
            end
        end
    end

    // result side ready, with random stalls and requested hold-offs
    initial
    begin
        int n;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (n = 0; n < hold_len; n++)
                    @(negedge clk);
            end
            else
                m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic send_request(input request_t r);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 19)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        expected_display.push_back(predict_display(r));
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_display.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TMR_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_IDLE_TIMEOUT:  cfg_idle   = val;
            CFG_REPEAT_PERIOD: cfg_repeat = val;
            CFG_AUTO_PERIOD:   cfg_auto   = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_timers(input logic [TMR_W-1:0] idle, input logic [TMR_W-1:0] rep,
                              input logic [TMR_W-1:0] auto_p);
        drain_results();
        write_reg(CFG_IDLE_TIMEOUT, idle);
        write_reg(CFG_REPEAT_PERIOD, rep);
        write_reg(CFG_AUTO_PERIOD, auto_p);
    endtask

    // button activity: held levels persist, calm spans of ticks let the idle
    // timer run out and the countdown reach zero
    task automatic send_random(input int count);
        request_t r;
        int k;
        for (k = 0; k < count; k++)
        begin
            r = '0;
            if (calm_left > 0)
            begin
                calm_left--;
                r.tick = ($urandom_range(0, 99) < 85);
            end
            else if ($urandom_range(0, 99) < 8)
                r = request_t'(8'($urandom_range(0, 63)));
            else
            begin
                if ($urandom_range(0, 99) < 3)
                begin
                    calm_left = $urandom_range(10, 60);
                    inc_level = 1'b0;
                    dec_level = 1'b0;
                end
                if ($urandom_range(0, 99) < 4) inc_level = ~inc_level;
                if ($urandom_range(0, 99) < 4) dec_level = ~dec_level;
                r.tick     = ($urandom_range(0, 99) < 75);
                r.rst_evt  = ($urandom_range(0, 99) < 3);
                r.inc_evt  = ($urandom_range(0, 99) < 6);
                r.dec_evt  = ($urandom_range(0, 99) < 6);
                r.inc_held = inc_level;
                r.dec_held = dec_level;
            end
            send_request(r);
        end
    endtask

    task automatic test_directed();
        // init, reset, both wraps, all inputs at once, both holds (the increment
        // one with an unserved press), idle timeout into countdown down to zero
        logic [5:0] seq [26] = '{
            6'h00, 6'h02, 6'h00, 6'h08, 6'h00, 6'h04, 6'h00, 6'h3F,
            6'h00, 6'h00, 6'h00, 6'h00, 6'h10, 6'h19, 6'h11, 6'h11,
            6'h00, 6'h00, 6'h20, 6'h21, 6'h21, 6'h00, 6'h01, 6'h01,
            6'h01, 6'h01
        };
        int k;
        set_timers(16'd2, 16'd2, 16'd1);
        for (k = 0; k < 26; k++)
            send_request(request_t'({2'b00, seq[k]}));
    endtask

    task automatic test_short_timers();
        set_timers(16'd3, 16'd2, 16'd1);
        send_random(300);
    endtask

    task automatic test_minimum_timers();
        set_timers(16'd1, 16'd1, 16'd1);
        no_idle = 1'b1;
        send_random(300);
        drain_results();
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        set_timers(16'd20, 16'd5, 16'd3);
        hold_len = 80;
        hold_req = 1'b1;
        send_random(150);
        drain_results();
        send_random(150);
    endtask

    task automatic test_zero_timers();
        set_timers(16'd0, 16'd0, 16'd0);
        send_random(200);
    endtask

    task automatic test_maximum_timers();
        set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_random(200);
    endtask

    task automatic test_random_timers();
        int k;
        for (k = 0; k < 3; k++)
        begin
            set_timers(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                       16'($urandom_range(1, 40)));
            send_random(200);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        hold_len  = 0;
        inc_level = 1'b0;
        dec_level = 1'b0;
        calm_left = 0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        auto_entries    = 0;
        hold_entries    = 0;
        reset_predictor();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_short_timers();
        test_minimum_timers();
        test_backpressure();
        test_zero_timers();
        test_maximum_timers();
        test_random_timers();

        drain_results();
        repeat (4) @(posedge clk);
        if (expected_display.size() != 0)
        begin
            $error("%0d results never arrived", expected_display.size());
            errors++;
        end
        $display("%0d requests, %0d results checked, %0d register writes",
                 items_sent, results_checked, reg_writes);
        $display("countdown entered %0d times, button held %0d times",
                 auto_entries, hold_entries);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: digit_counter_button_fsm_core.f
rtl/core/dcb_pkg.sv
rtl/core/dcb_timers.sv
rtl/core/dcb_fsm.sv
rtl/core/digit_counter_button_fsm_core.sv
bench/testbench.sv
